@@ sv/lrukvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrukvc_pkg
// Shared sizes, payload types and control structs of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lrukvc_pkg;

    // store geometry
    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;

    // field widths
    localparam int WORD_W = 32;
    localparam int CAP_W  = 5;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int EFF_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int KEY_W  = (KEY_BITS < WORD_W) ? KEY_BITS : WORD_W;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // request actions
    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } action_t;

    // request payload
    typedef struct packed {
        action_t            action;
        logic [WORD_W-1:0]  key;
        logic [WORD_W-1:0]  value;
    } req_t;

    // response payload
    typedef struct packed {
        logic               hit;
        logic [WORD_W-1:0]  read_value;
    } rsp_t;

    // request handed to the store, with its commit strobe
    typedef struct packed {
        logic   fire;
        req_t   req;
    } cmd_t;

    // capacity register write
    typedef struct packed {
        logic               write;
        logic [CAP_W-1:0]   data;
    } cfg_t;

endpackage

@@ sv/lru_key_value_cache_top.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Use:
//   request channel req_valid / req_stall / req_data carries a get or a put
//   with its key and value; a request is taken on a clock edge where
//   req_valid is high and req_stall is low.
//   response channel rsp_valid / rsp_stall / rsp_data returns hit and
//   read_value, one response per request, in request order.
//   cfg_valid / cfg_ready / cfg_data writes the capacity register; the
//   write only takes effect while the cache holds no entries.
// Timing:
//   a request lands in the input register, then is looked up and committed
//   to the store as it moves into the response register, where its response
//   is then valid. One request per cycle is sustained while rsp_stall is low;
//   the key compare, rank update and replacement choice all sit between the
//   input register and the response register.
// Reset:
//   rst_n clears all valid marks, ranks and occupancy and sets capacity
//   to sixteen. Entry keys and values are not cleared.
// Stall:
//   while rsp_stall holds a response, the input register keeps one more
//   request, then req_stall rises until the response is taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
    import lrukvc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_t                req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_t                rsp_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_W-1:0]    cfg_data
);

    logic   s1_valid_reg, s1_valid_next;
    req_t   s1_data_reg;
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_t   rsp_data_reg;

    logic   advance;
    logic   accept;
    cmd_t   cmd;
    cfg_t   cfg;
    rsp_t   result;

    // handshake
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    assign cmd.fire = advance;
    assign cmd.req  = s1_data_reg;
    assign cfg.write = cfg_valid && cfg_ready;
    assign cfg.data  = cfg_data;

    // store and lookup
    lrukvc_store u_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .rsp    (result)
    );

    // pipeline valid flags
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= req_data;
        end
        if (advance)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

@@ sv/lrukvc_store.sv @@
// ----------------------------------------------------------------------------
// lrukvc_store
// Entry storage, parallel key match, recency ranks and replacement choice.
// ----------------------------------------------------------------------------
module lrukvc_store
    import lrukvc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  cfg_t    cfg,
    output rsp_t    rsp
);

    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [KEY_W-1:0]       key_reg   [ENTRIES];
    logic [WORD_W-1:0]      value_reg [ENTRIES];
    logic [IDX_W-1:0]       rank_reg  [ENTRIES];
    logic [IDX_W-1:0]       rank_next [ENTRIES];
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic [CAP_W-1:0]       cap_reg;

    logic [KEY_W-1:0]       req_key;
    logic [ENTRIES-1:0]     match;
    logic                   hit;
    logic [IDX_W-1:0]       found_idx;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       victim_idx;
    logic [OCC_W-1:0]       occ_m1;
    logic [IDX_W-1:0]       oldest;
    logic [EFF_W-1:0]       cap_ext;
    logic [EFF_W-1:0]       eff_cap;
    logic                   room;
    logic                   is_put;

    // write decision
    logic                   do_write;
    logic                   do_promote;
    logic                   age_all;
    logic [IDX_W-1:0]       slot;
    logic [IDX_W-1:0]       old_rank;

    assign req_key = cmd.req.key[KEY_W-1:0];
    assign is_put  = (cmd.req.action == ACT_PUT);

    // parallel key compare
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req_key);
        end
    end

    assign hit = |match;

    // lowest matching, free and oldest slots
    always_comb
    begin
        found_idx  = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == oldest))
            begin
                victim_idx = IDX_W'(i);
            end
        end
    end

    assign occ_m1 = occ_reg - OCC_W'(1);
    assign oldest = occ_m1[IDX_W-1:0];

    // capacity clamped to one..entries
    assign cap_ext = EFF_W'(cap_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = EFF_W'(1);
        end
        else if (cap_ext > EFF_W'(ENTRIES))
        begin
            eff_cap = EFF_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign room = EFF_W'(occ_reg) < eff_cap;

    // response
    always_comb
    begin
        rsp.hit = hit;
        if (is_put)
        begin
            rsp.read_value = '0;
        end
        else if (hit)
        begin
            rsp.read_value = value_reg[found_idx];
        end
        else
        begin
            rsp.read_value = '1;
        end
    end

    // pick slot and promotion mode
    always_comb
    begin
        do_write   = 1'b0;
        do_promote = 1'b0;
        age_all    = 1'b0;
        slot       = found_idx;
        old_rank   = rank_reg[found_idx];
        occ_next   = occ_reg;
        if (cmd.fire)
        begin
            if (hit)
            begin
                do_promote = 1'b1;
                do_write   = is_put;
            end
            else if (is_put && room)
            begin
                do_promote = 1'b1;
                do_write   = 1'b1;
                age_all    = 1'b1;
                slot       = free_idx;
                occ_next   = occ_reg + OCC_W'(1);
            end
            else if (is_put)
            begin
                do_promote = 1'b1;
                do_write   = 1'b1;
                slot       = victim_idx;
                old_rank   = oldest;
            end
        end
    end

    // rank and valid update
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_promote)
            begin
                if (slot == IDX_W'(i))
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (age_all || (rank_reg[i] < old_rank)))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
        end
        if (do_write)
        begin
            valid_next[slot] = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (cfg.write && (occ_reg == '0))
            begin
                cap_reg <= cfg.data;
            end
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            key_reg[slot]   <= req_key;
            value_reg[slot] <= cmd.req.value;
        end
    end

`ifndef SYNTHESIS
    // occupancy tracks the valid marks
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy does not match valid entries");

    // never more entries than the clamped capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        EFF_W'(occ_reg) <= eff_cap)
        else $error("occupancy above capacity");

    // a key lives in at most one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("duplicate key in store");

    // a put that misses into a full store keeps occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fire && is_put && !hit && !room) |=> $stable(occ_reg))
        else $error("eviction changed occupancy");
`endif

endmodule

@@ dv/tb_lru_key_value_cache_top.sv @@
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Self-checking bench for the LRU key/value cache: a local cache model
// predicts hit and read_value for every accepted request, and each response
// is compared in order. Directed gets and puts cover capacity writes, field
// extremes, updates and eviction, then random traffic runs under three
// idling mixes on the request and response channels.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lrukvc_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 4;
    localparam int POOL_SIZE    = ENTRIES + 4;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_t               req_data = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_t               rsp_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data = '0;

    // idling mix, in percent of cycles
    int                 send_idle_pct = 9;
    int                 recv_idle_pct = 78;

    int                 mismatch_count = 0;
    int                 cycle_count = 0;

    // cache model state
    logic               cache_valid [ENTRIES];
    logic [KEY_W-1:0]   cache_key   [ENTRIES];
    logic [WORD_W-1:0]  cache_value [ENTRIES];
    int unsigned        cache_rank  [ENTRIES];
    int unsigned        cache_fill;
    logic [CAP_W-1:0]   capacity_reg;

    // responses still owed by the cache, oldest first
    rsp_t               pending_rsps [$];

    // keys that random traffic reuses so that hits and evictions happen
    logic [WORD_W-1:0]  key_pool [POOL_SIZE];

    lru_key_value_cache_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** lru_key_value_cache_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // cache model
    // ------------------------------------------------------------------------

    // capacity clamped to 1..ENTRIES
    function automatic int unsigned usable_entries();
        int unsigned cap;
        cap = 32'(capacity_reg);
        if (cap < 1)
            cap = 1;
        if (cap > ENTRIES)
            cap = ENTRIES;
        return cap;
    endfunction

    // slot becomes most recent, younger valid entries age one step
    function void make_most_recent(input int slot, input int unsigned old_rank);
        for (int i = 0; i < ENTRIES; i++)
            if (i != slot && cache_valid[i] && cache_rank[i] < old_rank)
                cache_rank[i]++;
        cache_rank[slot] = 0;
    endfunction

    function rsp_t predict_access(input req_t r);
        rsp_t           rsp;
        int             found;
        int             slot;
        int unsigned    oldest;
        found = -1;
        slot  = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && cache_valid[i] && cache_key[i] == r.key[KEY_W-1:0])
                found = i;
        rsp.hit = (found >= 0);

        // lookup
        if (r.action == ACT_GET)
        begin
            if (found >= 0)
            begin
                rsp.read_value = cache_value[found];
                make_most_recent(found, cache_rank[found]);
            end
            else
                rsp.read_value = '1;
            return rsp;
        end

        // put hit: overwrite in place
        rsp.read_value = '0;
        if (found >= 0)
        begin
            cache_value[found] = r.value;
            make_most_recent(found, cache_rank[found]);
            return rsp;
        end

        // put miss: free slot while below capacity, else least recent
        if (cache_fill < usable_entries())
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !cache_valid[i])
                    slot = i;
            if (slot < 0)
                slot = 0;
            make_most_recent(slot, ENTRIES + 1);
            cache_fill++;
        end
        else
        begin
            oldest = (cache_fill > 0) ? cache_fill - 1 : 0;
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && cache_valid[i] && cache_rank[i] == oldest)
                    slot = i;
            if (slot < 0)
                slot = 0;
            make_most_recent(slot, oldest);
        end
        cache_valid[slot] = 1'b1;
        cache_key[slot]   = r.key[KEY_W-1:0];
        cache_value[slot] = r.value;
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // response checking
    // ------------------------------------------------------------------------

    task report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task check_response(input rsp_t got);
        rsp_t want;
        if (pending_rsps.size() == 0)
        begin
            report_mismatch($sformatf("unexpected response hit=%0b read_value=%h",
                                      got.hit, got.read_value));
            return;
        end
        want = pending_rsps.pop_front();
        if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
        if (got.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      got.read_value, want.read_value));
    endtask

    // response sink with random stall
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_response(rsp_data);
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    function req_t make_req(input action_t act, input logic [WORD_W-1:0] key,
                            input logic [WORD_W-1:0] value);
        req_t r;
        r.action = act;
        r.key    = key;
        r.value  = value;
        return r;
    endfunction

    // one request, with a random gap ahead of it
    task send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        pending_rsps.push_back(predict_access(r));
    endtask

    // hold off requests until every response is back
    task wait_drained();
        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // capacity write, only ever issued with the cache idle
    task write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (cache_fill == 0)
            capacity_reg = cap;
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function req_t random_request();
        req_t           r;
        int unsigned    span;
        span     = usable_entries() + 3;
        r.action = action_t'($urandom_range(1));
        if ($urandom_range(99) < 85)
            r.key = key_pool[$urandom_range(span - 1)];
        else
            r.key = $urandom();
        r.value = $urandom();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // capacity above the store, zero, the reset value, then the setting for the run
    task test_capacity_register();
        logic [CAP_W-1:0] run_cap;
        write_capacity(5'd31);
        send_request(make_req(ACT_GET, 32'h8000_0000, 32'h0000_0000));
        write_capacity(5'd0);
        send_request(make_req(ACT_GET, 32'h7fff_ffff, 32'hffff_ffff));
        write_capacity(CAP_RESET);
        case ($urandom_range(5))
            0:       run_cap = 5'd0;
            1:       run_cap = 5'd1;
            2:       run_cap = 5'd2;
            3:       run_cap = 5'd16;
            4:       run_cap = 5'd31;
            default: run_cap = CAP_W'($urandom_range(1, ENTRIES));
        endcase
        write_capacity(run_cap);
    endtask

    // extreme keys and values, update of a present key, miss on an absent key
    task test_field_extremes();
        send_request(make_req(ACT_PUT, 32'h8000_0000, 32'h7fff_ffff));
        send_request(make_req(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000));
        send_request(make_req(ACT_PUT, 32'h0000_0000, 32'h0000_0000));
        send_request(make_req(ACT_PUT, 32'hffff_ffff, 32'hffff_ffff));
        send_request(make_req(ACT_GET, 32'h8000_0000, 32'h0000_0000));
        send_request(make_req(ACT_GET, 32'h7fff_ffff, 32'h0000_0000));
        send_request(make_req(ACT_GET, 32'h0000_0000, 32'hffff_ffff));
        send_request(make_req(ACT_GET, 32'hffff_ffff, 32'h0000_0000));
        send_request(make_req(ACT_PUT, 32'h0000_0000, 32'h1234_5678));
        send_request(make_req(ACT_GET, 32'h0000_0000, 32'h0000_0000));
        send_request(make_req(ACT_GET, 32'h5555_aaaa, 32'h0000_0000));
    endtask

    // fill past the capacity so the least recent entries get replaced
    task test_eviction();
        for (int i = 0; i < ENTRIES - 2; i++)
            send_request(make_req(ACT_PUT, 32'h1000_0000 + i, 32'ha000_0000 + i));
        send_request(make_req(ACT_GET, 32'h1000_0000, 32'h0000_0000));
        send_request(make_req(ACT_GET, 32'h8000_0000, 32'h0000_0000));
    endtask

    // capacity writes with entries present must leave the setting alone
    task test_capacity_locked();
        write_capacity(5'd1);
        send_request(make_req(ACT_PUT, 32'h2000_0001, 32'h0bad_f00d));
        send_request(make_req(ACT_PUT, 32'h2000_0002, 32'h0bad_f00e));
        write_capacity(5'd31);
        send_request(make_req(ACT_GET, 32'h2000_0001, 32'h0000_0000));
        send_request(make_req(ACT_GET, 32'h2000_0002, 32'h0000_0000));
    endtask

    // random gets and puts over a reused key set
    task test_random_traffic(input int count, input int send_pct, input int recv_pct,
                             input bit drain_midway);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < count; k++)
        begin
            if (drain_midway && k == count / 2)
                wait_drained();
            send_request(random_request());
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_value[i] = '0;
            cache_rank[i]  = 0;
        end
        cache_fill   = 0;
        capacity_reg = CAP_RESET;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_capacity_register();
        test_field_extremes();
        test_eviction();
        test_capacity_locked();
        test_random_traffic(330, 9, 78, 1'b1);
        test_random_traffic(330, 78, 9, 1'b0);
        test_random_traffic(340, 0, 0, 1'b0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("** lru_key_value_cache_top: PASSED **");
        else
            $display("** lru_key_value_cache_top: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
sv/lrukvc_pkg.sv
sv/lrukvc_store.sv
sv/lru_key_value_cache_top.sv
dv/tb_lru_key_value_cache_top.sv
